// ===== rtl/core/gls_pkg.sv =====
`timescale 1ns / 1ps

package gls_pkg;

  // default grid edge length in cells
  localparam int GRID_DIM_DEF = 64;

  // coordinate width as carried by the ports
  localparam int COORD_W = 7;
  // walk coordinate: one extra bit so a step off either edge reads as outside
  localparam int WALK_W  = COORD_W + 1;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam int            CFG_IDX_W       = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_LEVEL  = 2'd1;

  // register reset values (8-bit fractions)
  localparam logic [7:0] BLOCK_LEVEL_RST = 8'd218;
  localparam logic [7:0] COST_LEVEL_RST  = 8'd179;

  // terrain codes
  localparam logic [2:0] CT_OPEN     = 3'd0;
  localparam logic [2:0] CT_OBSTACLE = 3'd1;
  localparam logic [2:0] CT_WATER    = 3'd2;
  localparam logic [2:0] CT_TREE     = 3'd3;
  localparam logic [2:0] CT_MOUNTAIN = 3'd4;
  localparam logic [2:0] CT_SWAMP    = 3'd5;

  // one stored grid cell
  typedef struct packed {
    logic [2:0] cell_type;
    logic [7:0] altitude;
  } gls_cell_t;

  // mountain thresholds
  typedef struct packed {
    logic [7:0] block_level;
    logic [7:0] cost_level;
  } gls_cfg_t;

  // querying agent's house
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } gls_house_t;

endpackage

// ===== rtl/core/grid_line_of_sight_top.sv =====
`timescale 1ns / 1ps
// write beat: no result; the block stays idle and is ready again the next cycle
// query: the beat is taken, each visited cell is read and tested in turn, then the result is posted;
//   at a 64 grid the walk visits at most 127 cells inside the grid plus the one that leaves it
// the post waits while a held result is stalled; a posted result waits as the next beat is taken
// reset (synchronous, rst_n low) clears control state and loads the threshold resets, then a
//   clearing pass writes open ground to all 4096 store entries at a 64 grid, input stalled

module grid_line_of_sight_top #(
  parameter int GRID_DIM = gls_pkg::GRID_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [gls_pkg::COORD_W-1:0]        in_start_x,
  input  logic [gls_pkg::COORD_W-1:0]        in_start_y,
  input  logic [gls_pkg::COORD_W-1:0]        in_end_x,
  input  logic [gls_pkg::COORD_W-1:0]        in_end_y,
  input  logic [2:0]                         in_cell_type,
  input  logic [7:0]                         in_altitude,
  input  logic                               in_house_valid,
  input  logic [gls_pkg::COORD_W-1:0]        in_house_x,
  input  logic [gls_pkg::COORD_W-1:0]        in_house_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_visible,
  // configuration port
  input  logic                               cfg_we,
  input  logic [gls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);

  localparam int CB    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int AW    = 2 * CB;
  localparam int DEPTH = 1 << AW;
  localparam int WW    = gls_pkg::WALK_W;
  localparam logic [WW-1:0] GRID_LIM = WW'(GRID_DIM);
  localparam logic [AW-1:0] CLR_LAST = {AW{1'b1}};

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_RESULT = 4'b1000
  } gls_state_t;

  gls_state_t          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  gls_pkg::gls_cfg_t   cfg_r;
  gls_pkg::gls_house_t house_r, house_nxt;

  // walk registers
  logic [WW-1:0]       x_r, x_nxt;
  logic [WW-1:0]       y_r, y_nxt;
  logic                sx_r, sx_nxt;
  logic                sy_r, sy_nxt;
  logic [7:0]          dx2_r, dx2_nxt;
  logic [7:0]          dy2_r, dy2_nxt;
  logic signed [9:0]   err_r, err_nxt;
  logic [8:0]          n_r, n_nxt;
  logic                in_grid_r, in_grid_nxt;
  logic                vis_r, vis_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_visible_r, out_visible_nxt;

  // cell store
  gls_pkg::gls_cell_t  mem [DEPTH];
  gls_pkg::gls_cell_t  rd_data_r;
  gls_pkg::gls_cell_t  mem_wdata;
  logic [AW-1:0]       mem_waddr;
  logic                mem_we;
  logic [AW-1:0]       rd_addr;

  logic                in_beat;
  logic                out_free;
  logic                cell_ok;
  logic                diag;
  logic [8:0]          n_dec;
  logic [WW-1:0]       x_step, y_step;
  logic signed [9:0]   err_step;
  logic [gls_pkg::COORD_W-1:0] adx, ady;
  logic                wr_in_grid;

  assign in_beat   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_level <= gls_pkg::BLOCK_LEVEL_RST;
      cfg_r.cost_level  <= gls_pkg::COST_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gls_pkg::REG_BLOCK_LEVEL: cfg_r.block_level <= cfg_data;
        gls_pkg::REG_COST_LEVEL:  cfg_r.cost_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell test for the walk
  gls_cell_check u_cell_check (
    .cell_data (rd_data_r),
    .in_grid   (in_grid_r),
    .pos_x     (x_r),
    .pos_y     (y_r),
    .house     (house_r),
    .cfg       (cfg_r),
    .clear     (cell_ok)
  );

  // query setup terms
  assign adx = (in_end_x > in_start_x) ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
  assign ady = (in_end_y > in_start_y) ? (in_end_y - in_start_y) : (in_start_y - in_end_y);
  assign wr_in_grid = ({1'b0, in_start_x} < GRID_LIM) && ({1'b0, in_start_y} < GRID_LIM);

  // one bresenham step from the current cell
  always_comb begin
    diag     = 1'b0;
    x_step   = x_r;
    y_step   = y_r;
    err_step = err_r;
    if (err_r > 10'sd0) begin
      x_step   = sx_r ? x_r + 1'b1 : x_r - 1'b1;
      err_step = err_r - $signed({2'b00, dy2_r});
    end else if (err_r < 10'sd0) begin
      y_step   = sy_r ? y_r + 1'b1 : y_r - 1'b1;
      err_step = err_r + $signed({2'b00, dx2_r});
    end else begin
      diag     = 1'b1;
      x_step   = sx_r ? x_r + 1'b1 : x_r - 1'b1;
      y_step   = sy_r ? y_r + 1'b1 : y_r - 1'b1;
      err_step = err_r + $signed({2'b00, dx2_r}) - $signed({2'b00, dy2_r});
    end
    n_dec = diag ? 9'd2 : 9'd1;
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    house_nxt       = house_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    sx_nxt          = sx_r;
    sy_nxt          = sy_r;
    dx2_nxt         = dx2_r;
    dy2_nxt         = dy2_r;
    err_nxt         = err_r;
    n_nxt           = n_r;
    in_grid_nxt     = in_grid_r;
    vis_nxt         = vis_r;
    out_valid_nxt   = out_valid_r;
    out_visible_nxt = out_visible_r;
    mem_we          = 1'b0;
    mem_waddr       = clr_cnt_r;
    mem_wdata       = '0;
    rd_addr         = {y_r[CB-1:0], x_r[CB-1:0]};

    // result beat leaves
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          if (in_kind == gls_pkg::KIND_QUERY) begin
            house_nxt.valid = in_house_valid;
            house_nxt.x     = in_house_x;
            house_nxt.y     = in_house_y;
            x_nxt       = {1'b0, in_start_x};
            y_nxt       = {1'b0, in_start_y};
            sx_nxt      = in_end_x > in_start_x;
            sy_nxt      = in_end_y > in_start_y;
            dx2_nxt     = {adx, 1'b0};
            dy2_nxt     = {ady, 1'b0};
            err_nxt     = $signed({3'b000, adx}) - $signed({3'b000, ady});
            n_nxt       = 9'({2'b00, adx}) + 9'({2'b00, ady}) + 9'd1;
            in_grid_nxt = wr_in_grid;
            rd_addr     = {in_start_y[CB-1:0], in_start_x[CB-1:0]};
            state_nxt   = ST_WALK;
          end else if (wr_in_grid) begin
            mem_we              = 1'b1;
            mem_waddr           = {in_start_y[CB-1:0], in_start_x[CB-1:0]};
            mem_wdata.cell_type = in_cell_type;
            mem_wdata.altitude  = in_altitude;
          end
        end
      end
      ST_WALK: begin
        if (!cell_ok) begin
          vis_nxt   = 1'b0;
          state_nxt = ST_RESULT;
        end else if (n_r <= n_dec) begin
          vis_nxt   = 1'b1;
          state_nxt = ST_RESULT;
        end else begin
          n_nxt       = n_r - n_dec;
          x_nxt       = x_step;
          y_nxt       = y_step;
          err_nxt     = err_step;
          in_grid_nxt = (x_step < GRID_LIM) && (y_step < GRID_LIM);
          rd_addr     = {y_step[CB-1:0], x_step[CB-1:0]};
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_visible_nxt = vis_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    house_r       <= house_nxt;
    x_r           <= x_nxt;
    y_r           <= y_nxt;
    sx_r          <= sx_nxt;
    sy_r          <= sy_nxt;
    dx2_r         <= dx2_nxt;
    dy2_r         <= dy2_nxt;
    err_r         <= err_nxt;
    n_r           <= n_nxt;
    in_grid_r     <= in_grid_nxt;
    vis_r         <= vis_nxt;
    out_visible_r <= out_visible_nxt;
  end

  // cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result beat posted outside the result state");

  a_walk_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (n_r != 9'd0))
    else $error("walk running with no count left");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_kind == gls_pkg::KIND_WRITE) |=> (state_r == ST_IDLE))
    else $error("write beat left the idle state");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_cnt_r == CLR_LAST) |=> (state_r == ST_IDLE))
    else $error("clearing pass did not end on its last entry");

endmodule

// ===== rtl/core/gls_cell_check.sv =====
`timescale 1ns / 1ps

module gls_cell_check (
  input  gls_pkg::gls_cell_t            cell_data,
  input  logic                          in_grid,
  input  logic [gls_pkg::WALK_W-1:0]    pos_x,
  input  logic [gls_pkg::WALK_W-1:0]    pos_y,
  input  gls_pkg::gls_house_t           house,
  input  gls_pkg::gls_cfg_t             cfg,
  output logic                          clear
);

  logic at_house;
  logic too_high;

  // obstacle at the agent's own house lets the line through
  assign at_house = house.valid
                 && (pos_x == {1'b0, house.x})
                 && (pos_y == {1'b0, house.y});

  // mountain above either threshold blocks sight
  assign too_high = (cell_data.altitude > cfg.block_level)
                 || (cell_data.altitude > cfg.cost_level);

  // terrain classification
  always_comb begin
    case (cell_data.cell_type)
      gls_pkg::CT_OBSTACLE: clear = at_house;
      gls_pkg::CT_WATER:    clear = 1'b0;
      gls_pkg::CT_TREE:     clear = 1'b0;
      gls_pkg::CT_SWAMP:    clear = 1'b0;
      gls_pkg::CT_MOUNTAIN: clear = !too_high;
      default:              clear = 1'b1;
    endcase
    if (!in_grid) begin
      clear = 1'b0;
    end
  end

endmodule
